// ===== rtl/column_zscore_normalizer_top_assert.svh =====
// Assertion macros shared by the checker of the column z-score normalizer.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef COLUMN_ZSCORE_NORMALIZER_TOP_ASSERT_SVH
`define COLUMN_ZSCORE_NORMALIZER_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define CZN_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CZN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/czn_pkg.sv =====
// ----------------------------------------------------------------------------
// czn_pkg
// Types and fixed widths shared by the column z-score normalizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package czn_pkg;

	localparam int SAMPLE_W  = 32;
	localparam int COL_W     = 4;
	localparam int STD_W     = 31;
	localparam int POS_W     = 6;
	localparam int SUM_W     = 38;
	localparam int CN_W      = 5;
	localparam int CNT_W     = 7;
	localparam int DIV_W     = 72;
	localparam int DIV_CNT_W = 7;
	localparam int ACC_W     = 71;
	localparam int ROOT_IN_W = 62;
	localparam int ROOT_W    = 31;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;

	localparam logic [STD_W-1:0] STD_MAX = '1;

	// Register indexes (paddr bit 2).
	localparam logic REG_USE_GIVEN = 1'b0;
	localparam logic REG_COLS_NORM = 1'b1;

	typedef enum logic [1:0] {
		CMD_PASS,
		CMD_GIVEN,
		CMD_FINISH
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                   kind;
		logic signed [SAMPLE_W-1:0]  sample;
		logic [COL_W-1:0]            col;
		logic                        last;
		logic signed [SAMPLE_W-1:0]  gmean;
		logic [STD_W-1:0]            gstd;
		logic [POS_W-1:0]            pos;
		logic signed [SUM_W-1:0]     sum;
		logic [CNT_W-1:0]            n;
	} cmd_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_DISPATCH,
		BK_MEAN_WAIT,
		BK_SQ_ADDR,
		BK_SQ_DIFF,
		BK_SQ_MUL,
		BK_SQ_ACC,
		BK_VAR_GO,
		BK_VAR_WAIT,
		BK_SQRT_WAIT,
		BK_NRM_ADDR,
		BK_NRM_DIFF,
		BK_NRM_GO,
		BK_NRM_WAIT,
		BK_OUT
	} bk_state_t;

endpackage

`default_nettype wire

// ===== rtl/czn_ram.sv =====
// ----------------------------------------------------------------------------
// czn_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module czn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire                      re,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/czn_div.sv =====
// ----------------------------------------------------------------------------
// czn_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module czn_div (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	input  wire [czn_pkg::DIV_W-1:0]        dividend,
	input  wire [czn_pkg::STD_W-1:0]        divisor,
	input  wire [czn_pkg::DIV_CNT_W-1:0]    nbits,
	output logic                            done,
	output logic [czn_pkg::DIV_W-1:0]       quotient
);

	logic [czn_pkg::DIV_W-1:0]     num_q;
	logic [czn_pkg::STD_W-1:0]     den_q;
	logic [czn_pkg::STD_W-1:0]     rem_q;
	logic [czn_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [czn_pkg::STD_W:0]       rem_w;
	logic                          ge;
	logic [czn_pkg::STD_W:0]       rem_sub;
	logic [czn_pkg::DIV_CNT_W-1:0] shamt;

	assign shamt   = czn_pkg::DIV_CNT_W'(czn_pkg::DIV_W) - nbits;
	assign rem_w   = {rem_q, num_q[czn_pkg::DIV_W-1]};
	assign ge      = rem_w >= {1'b0, den_q};
	assign rem_sub = rem_w - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == czn_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend << shamt;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[czn_pkg::DIV_W-2:0], ge};
			rem_q <= ge ? rem_sub[czn_pkg::STD_W-1:0] : rem_w[czn_pkg::STD_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

`default_nettype wire

// ===== rtl/czn_isqrt.sv =====
// ----------------------------------------------------------------------------
// czn_isqrt
// Integer square root, one result bit per cycle, with the remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module czn_isqrt (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	input  wire [czn_pkg::ROOT_IN_W-1:0]     operand,
	output logic                             done,
	output logic [czn_pkg::ROOT_W-1:0]       root,
	output logic [czn_pkg::ROOT_W:0]         remainder
);

	localparam logic [czn_pkg::ROOT_IN_W-1:0] BIT_INIT =
		czn_pkg::ROOT_IN_W'(1) << (czn_pkg::ROOT_IN_W - 2);

	logic [czn_pkg::ROOT_IN_W-1:0] v_q;
	logic [czn_pkg::ROOT_IN_W-1:0] r_q;
	logic [czn_pkg::ROOT_IN_W-1:0] bit_q;
	logic                          busy_q;
	logic                          done_q;
	logic [czn_pkg::ROOT_IN_W-1:0] trial;
	logic                          take;

	assign trial = r_q + bit_q;
	assign take  = v_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= operand;
			r_q   <= '0;
			bit_q <= BIT_INIT;
		end else if (busy_q) begin
			if (take) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done      = done_q;
	assign root      = r_q[czn_pkg::ROOT_W-1:0];
	assign remainder = v_q[czn_pkg::ROOT_W:0];

endmodule

`default_nettype wire

// ===== rtl/czn_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// czn_cmd_fifo
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module czn_cmd_fifo (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  czn_pkg::cmd_t       push_cmd,
	input  wire                 pop,
	output czn_pkg::cmd_t       head,
	output logic                full,
	output logic                empty
);

	czn_pkg::cmd_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	assign head  = entry_q[rd_ptr_q];
	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;

endmodule

`default_nettype wire

// ===== rtl/czn_front.sv =====
// ----------------------------------------------------------------------------
// czn_front
// Accepts items, stores computed-mode runs and queues commands for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module czn_front #(
	parameter int MAX_ROWS = 64
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    use_given,
	input  wire [czn_pkg::CN_W-1:0]                cols_norm,
	input  wire                                    cfg_wr,
	input  wire                                    in_valid,
	output logic                                   in_stall,
	input  wire signed [czn_pkg::SAMPLE_W-1:0]     sample,
	input  wire [czn_pkg::COL_W-1:0]               column,
	input  wire                                    last,
	input  wire signed [czn_pkg::SAMPLE_W-1:0]     given_mean,
	input  wire [czn_pkg::STD_W-1:0]               given_std,
	output logic                                   push,
	output czn_pkg::cmd_t                          push_cmd,
	input  wire                                    fifo_full,
	input  wire                                    finish_done,
	output logic                                   wr_en,
	output logic [$clog2(MAX_ROWS)-1:0]            wr_addr,
	output logic [czn_pkg::SAMPLE_W-1:0]           wr_data
);

	localparam int CW = $clog2(MAX_ROWS + 1);

	logic [CW-1:0]                    count_q;
	logic signed [czn_pkg::SUM_W-1:0] sum_q;
	logic [czn_pkg::COL_W-1:0]        run_col_q;
	logic [czn_pkg::POS_W-1:0]        pos_q;
	logic                             busy_q;

	logic                             accept;
	logic                             is_pass;
	logic                             full;
	logic                             store;
	logic signed [czn_pkg::SUM_W-1:0] sum_nx;

	assign in_stall = fifo_full | busy_q;
	assign accept   = in_valid & ~in_stall;
	assign is_pass  = {1'b0, column} >= cols_norm;
	assign full     = count_q == CW'(MAX_ROWS);
	assign store    = accept & ~is_pass & ~use_given & ~full;
	assign sum_nx   = sum_q + czn_pkg::SUM_W'(sample);

	assign wr_en   = store;
	assign wr_addr = count_q[$clog2(MAX_ROWS)-1:0];
	assign wr_data = sample;
	assign push    = accept & (is_pass | use_given | last);

	always_comb begin
		push_cmd        = '0;
		push_cmd.sample = sample;
		push_cmd.col    = column;
		push_cmd.last   = last;
		push_cmd.gmean  = given_mean;
		push_cmd.gstd   = given_std;
		push_cmd.pos    = pos_q;
		push_cmd.sum    = full ? sum_q : sum_nx;
		push_cmd.n      = czn_pkg::CNT_W'(full ? count_q : count_q + 1'b1);
		if (is_pass) begin
			push_cmd.kind = czn_pkg::CMD_PASS;
		end else if (use_given) begin
			push_cmd.kind = czn_pkg::CMD_GIVEN;
		end else begin
			push_cmd.kind = czn_pkg::CMD_FINISH;
			// The run keeps the column of its first stored item.
			push_cmd.col  = (count_q == '0) ? column : run_col_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			sum_q     <= '0;
			run_col_q <= '0;
			pos_q     <= '0;
			busy_q    <= 1'b0;
		end else begin
			if (finish_done) begin
				busy_q <= 1'b0;
			end
			if (cfg_wr) begin
				count_q <= '0;
				sum_q   <= '0;
				pos_q   <= '0;
			end else if (accept && !is_pass) begin
				if (use_given) begin
					pos_q <= last ? '0 : pos_q + 1'b1;
				end else if (last) begin
					// The run is closed; the back end now owns the stored samples.
					count_q <= '0;
					sum_q   <= '0;
					busy_q  <= 1'b1;
				end else if (store) begin
					count_q <= count_q + 1'b1;
					sum_q   <= sum_nx;
					if (count_q == '0) begin
						run_col_q <= column;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/czn_back.sv =====
// ----------------------------------------------------------------------------
// czn_back
// Executes queued commands: statistics, normalization and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module czn_back #(
	parameter int MAX_ROWS  = 64,
	parameter int FRAC_BITS = 16
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  fifo_empty,
	input  czn_pkg::cmd_t                        fifo_head,
	output logic                                 pop,
	output logic                                 rd_en,
	output logic [$clog2(MAX_ROWS)-1:0]          rd_addr,
	input  wire [czn_pkg::SAMPLE_W-1:0]          rd_data,
	output logic                                 finish_done,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic signed [czn_pkg::SAMPLE_W-1:0]  value,
	output logic [czn_pkg::POS_W-1:0]            position,
	output logic [czn_pkg::COL_W-1:0]            column_out,
	output logic                                 final_res,
	output logic signed [czn_pkg::SAMPLE_W-1:0]  mean_out,
	output logic [czn_pkg::STD_W-1:0]            std_out,
	output logic                                 zero_std
);

	localparam int CW       = czn_pkg::CNT_W;
	localparam int SW       = czn_pkg::SAMPLE_W;
	localparam int NRM_BITS = SW + FRAC_BITS + 1;
	localparam int MEAN_BITS = czn_pkg::SUM_W + 1;

	czn_pkg::bk_state_t state_q, state_d;

	czn_pkg::cmd_t                     cmd_q;
	logic signed [SW-1:0]              mean_q;
	logic [czn_pkg::STD_W-1:0]         std_q;
	logic [CW-1:0]                     idx_q;
	logic [czn_pkg::ACC_W-1:0]         acc_q;
	logic [SW-1:0]                     m_q;
	logic                              neg_q;
	logic [2*SW-1:0]                   sq_q;
	logic                              out_valid_q;

	logic                              div_start;
	logic [czn_pkg::DIV_W-1:0]         div_dividend;
	logic [czn_pkg::STD_W-1:0]         div_divisor;
	logic [czn_pkg::DIV_CNT_W-1:0]     div_nbits;
	logic                              div_done;
	logic [czn_pkg::DIV_W-1:0]         div_quo;
	logic                              sq_start;
	logic                              sq_done;
	logic [czn_pkg::ROOT_W-1:0]        sq_root;
	logic [czn_pkg::ROOT_W:0]          sq_rem;

	logic                              out_acc;
	logic                              is_finish;
	logic                              idx_last;
	logic                              var_sat;
	logic [czn_pkg::SUM_W-1:0]         sum_mag;
	logic signed [SW:0]                diff;
	logic signed [SW-1:0]              x_sel;
	logic signed [SW-1:0]              mean_sel;
	logic [SW-1:0]                     mean_q32;
	logic                              quo_big;
	logic signed [SW-1:0]              nrm_val;
	logic [SW-1:0]                     root_up;
	logic [czn_pkg::STD_W-1:0]         std_round;

	assign out_acc   = out_valid_q & ~out_stall;
	assign is_finish = cmd_q.kind == czn_pkg::CMD_FINISH;
	assign idx_last  = idx_q == cmd_q.n - 1'b1;
	assign var_sat   = |div_quo[czn_pkg::DIV_W-1:czn_pkg::ROOT_IN_W];
	assign sum_mag   = cmd_q.sum[czn_pkg::SUM_W-1] ? czn_pkg::SUM_W'(-cmd_q.sum)
	                                               : czn_pkg::SUM_W'(cmd_q.sum);
	assign x_sel     = (state_q == czn_pkg::BK_DISPATCH) ? cmd_q.sample : signed'(rd_data);
	assign mean_sel  = (state_q == czn_pkg::BK_DISPATCH) ? cmd_q.gmean : mean_q;
	assign diff      = (SW+1)'(x_sel) - (SW+1)'(mean_sel);
	assign mean_q32  = div_quo[SW-1:0];

	// Rounded and saturated quotient of the normalize division.
	assign quo_big = |div_quo[czn_pkg::DIV_W-1:SW-1];
	always_comb begin
		if (neg_q) begin
			nrm_val = quo_big ? {1'b1, {(SW-1){1'b0}}} : signed'(-div_quo[SW-1:0]);
		end else begin
			nrm_val = quo_big ? {1'b0, {(SW-1){1'b1}}} : signed'(div_quo[SW-1:0]);
		end
	end

	// Round the root to nearest: step up when the remainder exceeds the root.
	assign root_up = SW'(sq_root) + 1'b1;
	always_comb begin
		if (sq_rem > {1'b0, sq_root}) begin
			std_round = root_up[SW-1] ? czn_pkg::STD_MAX : root_up[czn_pkg::STD_W-1:0];
		end else begin
			std_round = sq_root;
		end
	end

	always_comb begin
		div_dividend = '0;
		div_divisor  = czn_pkg::STD_W'(cmd_q.n);
		div_nbits    = czn_pkg::DIV_CNT_W'(MEAN_BITS);
		unique case (state_q)
			czn_pkg::BK_DISPATCH: begin
				div_dividend = czn_pkg::DIV_W'(sum_mag) + czn_pkg::DIV_W'(cmd_q.n >> 1);
			end
			czn_pkg::BK_VAR_GO: begin
				div_dividend = czn_pkg::DIV_W'(acc_q);
				div_nbits    = czn_pkg::DIV_CNT_W'(czn_pkg::ACC_W);
			end
			default: begin
				div_dividend = (czn_pkg::DIV_W'(m_q) << FRAC_BITS)
				             + czn_pkg::DIV_W'(std_q >> 1);
				div_divisor  = std_q;
				div_nbits    = czn_pkg::DIV_CNT_W'(NRM_BITS);
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= czn_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and strobes.
	always_comb begin
		state_d     = state_q;
		pop         = 1'b0;
		rd_en       = 1'b0;
		div_start   = 1'b0;
		sq_start    = 1'b0;
		finish_done = 1'b0;
		unique case (state_q)
			czn_pkg::BK_IDLE: begin
				if (!fifo_empty) begin
					pop     = 1'b1;
					state_d = czn_pkg::BK_DISPATCH;
				end
			end
			czn_pkg::BK_DISPATCH: begin
				unique case (cmd_q.kind)
					czn_pkg::CMD_PASS: state_d = czn_pkg::BK_OUT;
					czn_pkg::CMD_GIVEN: state_d = czn_pkg::BK_NRM_GO;
					default: begin
						div_start = 1'b1;
						state_d   = czn_pkg::BK_MEAN_WAIT;
					end
				endcase
			end
			czn_pkg::BK_MEAN_WAIT: begin
				if (div_done) begin
					state_d = czn_pkg::BK_SQ_ADDR;
				end
			end
			czn_pkg::BK_SQ_ADDR: begin
				rd_en   = 1'b1;
				state_d = czn_pkg::BK_SQ_DIFF;
			end
			czn_pkg::BK_SQ_DIFF: state_d = czn_pkg::BK_SQ_MUL;
			czn_pkg::BK_SQ_MUL:  state_d = czn_pkg::BK_SQ_ACC;
			czn_pkg::BK_SQ_ACC: begin
				state_d = idx_last ? czn_pkg::BK_VAR_GO : czn_pkg::BK_SQ_ADDR;
			end
			czn_pkg::BK_VAR_GO: begin
				div_start = 1'b1;
				state_d   = czn_pkg::BK_VAR_WAIT;
			end
			czn_pkg::BK_VAR_WAIT: begin
				if (div_done) begin
					if (var_sat) begin
						state_d = czn_pkg::BK_NRM_ADDR;
					end else begin
						sq_start = 1'b1;
						state_d  = czn_pkg::BK_SQRT_WAIT;
					end
				end
			end
			czn_pkg::BK_SQRT_WAIT: begin
				if (sq_done) begin
					state_d = czn_pkg::BK_NRM_ADDR;
				end
			end
			czn_pkg::BK_NRM_ADDR: begin
				rd_en   = 1'b1;
				state_d = czn_pkg::BK_NRM_DIFF;
			end
			czn_pkg::BK_NRM_DIFF: state_d = czn_pkg::BK_NRM_GO;
			czn_pkg::BK_NRM_GO: begin
				if (std_q == '0) begin
					state_d = czn_pkg::BK_OUT;
				end else begin
					div_start = 1'b1;
					state_d   = czn_pkg::BK_NRM_WAIT;
				end
			end
			czn_pkg::BK_NRM_WAIT: begin
				if (div_done) begin
					state_d = czn_pkg::BK_OUT;
				end
			end
			czn_pkg::BK_OUT: begin
				if (out_acc) begin
					if (is_finish && !idx_last) begin
						state_d = czn_pkg::BK_NRM_ADDR;
					end else begin
						finish_done = is_finish;
						state_d     = czn_pkg::BK_IDLE;
					end
				end
			end
			default: state_d = czn_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_acc) begin
			out_valid_q <= 1'b0;
		end else if (state_q != czn_pkg::BK_OUT && state_d == czn_pkg::BK_OUT) begin
			out_valid_q <= 1'b1;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			czn_pkg::BK_IDLE: begin
				if (!fifo_empty) begin
					cmd_q <= fifo_head;
				end
			end
			czn_pkg::BK_DISPATCH: begin
				mean_q <= cmd_q.gmean;
				std_q  <= cmd_q.gstd;
				neg_q  <= diff[SW];
				m_q    <= diff[SW] ? SW'(-diff) : SW'(diff);
				idx_q  <= '0;
				if (cmd_q.kind == czn_pkg::CMD_PASS) begin
					value      <= cmd_q.sample;
					position   <= '0;
					column_out <= cmd_q.col;
					final_res  <= cmd_q.last;
					mean_out   <= '0;
					std_out    <= '0;
					zero_std   <= 1'b0;
				end
			end
			czn_pkg::BK_MEAN_WAIT: begin
				if (div_done) begin
					mean_q <= cmd_q.sum[czn_pkg::SUM_W-1] ? signed'(-mean_q32)
					                                      : signed'(mean_q32);
					acc_q  <= '0;
				end
			end
			czn_pkg::BK_SQ_DIFF: begin
				m_q <= diff[SW] ? SW'(-diff) : SW'(diff);
			end
			czn_pkg::BK_SQ_MUL: begin
				sq_q <= m_q * m_q;
			end
			czn_pkg::BK_SQ_ACC: begin
				acc_q <= acc_q + czn_pkg::ACC_W'(sq_q);
				idx_q <= idx_last ? '0 : idx_q + 1'b1;
			end
			czn_pkg::BK_VAR_WAIT: begin
				if (div_done && var_sat) begin
					std_q <= czn_pkg::STD_MAX;
				end
			end
			czn_pkg::BK_SQRT_WAIT: begin
				if (sq_done) begin
					std_q <= std_round;
				end
			end
			czn_pkg::BK_NRM_DIFF: begin
				neg_q <= diff[SW];
				m_q   <= diff[SW] ? SW'(-diff) : SW'(diff);
			end
			czn_pkg::BK_NRM_GO: begin
				column_out <= cmd_q.col;
				mean_out   <= mean_q;
				std_out    <= std_q;
				position   <= is_finish ? czn_pkg::POS_W'(idx_q) : cmd_q.pos;
				final_res  <= is_finish ? idx_last : cmd_q.last;
				zero_std   <= std_q == '0;
				value      <= '0;
			end
			czn_pkg::BK_NRM_WAIT: begin
				if (div_done) begin
					value <= nrm_val;
				end
			end
			czn_pkg::BK_OUT: begin
				if (out_acc && is_finish && !idx_last) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign rd_addr   = idx_q[$clog2(MAX_ROWS)-1:0];
	assign out_valid = out_valid_q;

	czn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.nbits    (div_nbits),
		.done     (div_done),
		.quotient (div_quo)
	);

	czn_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (sq_start),
		.operand   (div_quo[czn_pkg::ROOT_IN_W-1:0]),
		.done      (sq_done),
		.root      (sq_root),
		.remainder (sq_rem)
	);

endmodule

`default_nettype wire

// ===== rtl/column_zscore_normalizer_top.sv =====
// ----------------------------------------------------------------------------
// column_zscore_normalizer_top
// Z-score standardization of one data column per run, signed fixed point.
// ----------------------------------------------------------------------------
// Usage: samples enter as beats on the input channel (in_valid / in_stall) and
// normalized results leave as beats on the output channel (out_valid /
// out_stall). Two registers sit on the APB port: use_given_stats at byte
// address 0 and columns_normalized at byte address 4; any write drops a run
// that is still being collected.
// Pass-through and given-mode beats give one result each. A pass-through
// result is registered straight from its queued command; a given-mode result
// with a nonzero deviation waits on the bit-serial normalize divider.
// In computed mode samples are stored and give no result until the beat marked
// last. After it the block runs the mean divide, the sum of squares (read,
// difference, square and accumulate per stored sample), the variance divide
// and the square root, then a normalize divide per emitted result. Input beats
// are held off from the last beat until the run's final result is taken.
// Reset clears control state, not datapath registers; the sample store is not
// cleared, only entries of the current run are read. When the receiver stalls,
// the result register holds its beat and up to two later commands queue up in
// front of the back end before the input channel stalls too.
// ----------------------------------------------------------------------------
`default_nettype none

module column_zscore_normalizer_top #(
	parameter int MAX_ROWS  = 64,
	parameter int FRAC_BITS = 16
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// APB configuration port
	input  wire                                  psel,
	input  wire                                  penable,
	input  wire                                  pwrite,
	input  wire [czn_pkg::APB_AW-1:0]            paddr,
	input  wire [czn_pkg::APB_DW-1:0]            pwdata,
	output logic [czn_pkg::APB_DW-1:0]           prdata,
	output logic                                 pready,
	// Input channel
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire signed [czn_pkg::SAMPLE_W-1:0]   sample,
	input  wire [czn_pkg::COL_W-1:0]             column,
	input  wire                                  last,
	input  wire signed [czn_pkg::SAMPLE_W-1:0]   given_mean,
	input  wire [czn_pkg::STD_W-1:0]             given_std,
	// Output channel
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic signed [czn_pkg::SAMPLE_W-1:0]  value,
	output logic [czn_pkg::POS_W-1:0]            position,
	output logic [czn_pkg::COL_W-1:0]            column_out,
	output logic                                 final_res,
	output logic signed [czn_pkg::SAMPLE_W-1:0]  mean_out,
	output logic [czn_pkg::STD_W-1:0]            std_out,
	output logic                                 zero_std
);

	localparam int AW = $clog2(MAX_ROWS);

	logic                        use_given_q;
	logic [czn_pkg::CN_W-1:0]    cols_norm_q;
	logic                        cfg_wr;

	czn_pkg::cmd_t               push_cmd;
	czn_pkg::cmd_t               fifo_head;
	logic                        push;
	logic                        pop;
	logic                        fifo_full;
	logic                        fifo_empty;
	logic                        finish_done;

	logic                        wr_en;
	logic [AW-1:0]               wr_addr;
	logic [czn_pkg::SAMPLE_W-1:0] wr_data;
	logic                        rd_en;
	logic [AW-1:0]               rd_addr;
	logic [czn_pkg::SAMPLE_W-1:0] rd_data;

	// The register file always answers in the access cycle.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_given_q <= 1'b0;
			cols_norm_q <= czn_pkg::CN_W'(16);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				czn_pkg::REG_USE_GIVEN: use_given_q <= pwdata[0];
				czn_pkg::REG_COLS_NORM: cols_norm_q <= pwdata[czn_pkg::CN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			czn_pkg::REG_USE_GIVEN: prdata = czn_pkg::APB_DW'(use_given_q);
			czn_pkg::REG_COLS_NORM: prdata = czn_pkg::APB_DW'(cols_norm_q);
			default: prdata = '0;
		endcase
	end

	// Front end: classifies beats, writes the sample store, queues commands.
	czn_front #(
		.MAX_ROWS (MAX_ROWS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.use_given   (use_given_q),
		.cols_norm   (cols_norm_q),
		.cfg_wr      (cfg_wr),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample      (sample),
		.column      (column),
		.last        (last),
		.given_mean  (given_mean),
		.given_std   (given_std),
		.push        (push),
		.push_cmd    (push_cmd),
		.fifo_full   (fifo_full),
		.finish_done (finish_done),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data)
	);

	czn_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (fifo_head),
		.full     (fifo_full),
		.empty    (fifo_empty)
	);

	// Sample store for the run being collected.
	czn_ram #(
		.WIDTH (czn_pkg::SAMPLE_W),
		.DEPTH (MAX_ROWS)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Back end: statistics, divider, square root and the result register.
	czn_back #(
		.MAX_ROWS  (MAX_ROWS),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.fifo_empty  (fifo_empty),
		.fifo_head   (fifo_head),
		.pop         (pop),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.finish_done (finish_done),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.value       (value),
		.position    (position),
		.column_out  (column_out),
		.final_res   (final_res),
		.mean_out    (mean_out),
		.std_out     (std_out),
		.zero_std    (zero_std)
	);

endmodule

`default_nettype wire

// ===== rtl/czn_checker.sv =====
// ----------------------------------------------------------------------------
// czn_checker
// Port-level checks of the column z-score normalizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "column_zscore_normalizer_top_assert.svh"

module czn_checker (
	input wire                                  clk,
	input wire                                  arst_n,
	input wire                                  out_valid,
	input wire                                  out_stall,
	input wire signed [czn_pkg::SAMPLE_W-1:0]   value,
	input wire [czn_pkg::POS_W-1:0]             position,
	input wire signed [czn_pkg::SAMPLE_W-1:0]   mean_out,
	input wire [czn_pkg::STD_W-1:0]             std_out,
	input wire                                  zero_std
);

	// A stalled result beat stays up with the same value.
	`CZN_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(value), "result beat changed while stalled")

	// A zero deviation forces a zero value.
	`CZN_ASSERT_SAME(a_zero_std, clk, arst_n, out_valid && zero_std, value == 0 && std_out == 0, "zero deviation without zero value")

	// A zero deviation without the flag only comes from pass-through.
	`CZN_ASSERT_SAME(a_pass_fields, clk, arst_n, out_valid && std_out == 0 && !zero_std, mean_out == 0 && position == 0, "pass-through result carries statistics")

	// A positive deviation never raises the flag.
	`CZN_ASSERT_SAME(a_flag_std, clk, arst_n, out_valid && std_out != 0, !zero_std, "flag set with nonzero deviation")

endmodule

bind column_zscore_normalizer_top czn_checker u_czn_checker (.*);

`default_nettype wire
